FILE: hw/rtl/order_book_snapshot_table_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the order book snapshot table
// Shared property forms used by the top level checks.
// ---------------------------------------------------------------------------
`ifndef ORDER_BOOK_SNAPSHOT_TABLE_TOP_MACROS_SVH
`define ORDER_BOOK_SNAPSHOT_TABLE_TOP_MACROS_SVH

// implication checked each clock outside reset
`define OBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked each clock outside reset
`define OBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/obst_pkg.sv
// ---------------------------------------------------------------------------
// Order book snapshot table package
// Types, codes and defaults shared by the front, queue and back parts.
// ---------------------------------------------------------------------------
package obst_pkg;

    localparam int NUM_TICKERS_DEF       = 8;
    localparam int ORDERS_PER_TICKER_DEF = 1024;

    localparam logic [2:0] MSG_STATUS = 3'd0;
    localparam logic [2:0] MSG_START  = 3'd1;
    localparam logic [2:0] MSG_CLEAR  = 3'd2;
    localparam logic [2:0] MSG_ORDER  = 3'd3;
    localparam logic [2:0] MSG_END    = 3'd4;

    localparam logic [1:0] UPD_ADD    = 2'd0;
    localparam logic [1:0] UPD_MODIFY = 2'd1;
    localparam logic [1:0] UPD_CANCEL = 2'd2;
    localparam logic [1:0] UPD_OTHER  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_MISSING  = 2'd2;
    localparam logic [1:0] ST_SIDE     = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [1:0]  update_type;
        logic [31:0] seq_num;
        logic [2:0]  ticker;
        logic [9:0]  order_id;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  msg_type;
        logic [15:0] msg_seq;
        logic [2:0]  out_ticker;
        logic [31:0] id_or_last_seq;
        logic        out_side;
        logic [31:0] out_price;
        logic [31:0] out_qty;
        logic [1:0]  status;
        logic        seq_gap;
        logic        last_of_snapshot;
    } t_out_item;

    // classified command passed from front to back
    typedef struct packed {
        logic        tick;
        logic [1:0]  update_type;
        logic        in_range;
        logic [31:0] seq_num;
        logic        seq_gap;
        logic [2:0]  ticker;
        logic [9:0]  order_id;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
    } t_cmd;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_UPD,
        BK_SCAN,
        BK_SCAN_RD,
        BK_CLEAR_PASS
    } t_bk_state;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CLEAR,
        PH_ORDERS
    } t_walk_phase;

endpackage

FILE: hw/rtl/obst_front.sv
// ---------------------------------------------------------------------------
// Front part
// Accepts items, range checks them and flags sequence gaps.
// ---------------------------------------------------------------------------
module obst_front #(
    parameter int NUM_TICKERS       = obst_pkg::NUM_TICKERS_DEF,
    parameter int ORDERS_PER_TICKER = obst_pkg::ORDERS_PER_TICKER_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  obst_pkg::t_in_item i_item,
    input  logic              i_q_full,
    output logic              o_busy,
    output logic              o_push,
    output obst_pkg::t_cmd    o_cmd
);
    import obst_pkg::*;

    logic [31:0] r_last_seq;
    logic [31:0] n_last_seq;
    logic        w_take;

    assign o_busy = i_q_full;
    assign w_take = i_start && !i_q_full;
    assign o_push = w_take;

    always_comb begin
        o_cmd.tick        = i_item.kind;
        o_cmd.update_type = i_item.update_type;
        o_cmd.in_range    = (32'(i_item.ticker) < 32'(NUM_TICKERS))
                         && (32'(i_item.order_id) < 32'(ORDERS_PER_TICKER));
        o_cmd.seq_num     = i_item.seq_num;
        o_cmd.seq_gap     = (i_item.seq_num != r_last_seq + 32'd1);
        o_cmd.ticker      = i_item.ticker;
        o_cmd.order_id    = i_item.order_id;
        o_cmd.side        = i_item.side;
        o_cmd.price       = i_item.price;
        o_cmd.qty         = i_item.qty;
    end

    always_comb begin
        n_last_seq = r_last_seq;
        if (w_take && !i_item.kind) begin
            n_last_seq = i_item.seq_num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seq <= '0;
        end else begin
            r_last_seq <= n_last_seq;
        end
    end

endmodule

FILE: hw/rtl/obst_queue.sv
// ---------------------------------------------------------------------------
// Command queue
// Two-entry queue between the front and back parts.
// ---------------------------------------------------------------------------
module obst_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  obst_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output obst_pkg::t_cmd o_cmd
);
    import obst_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

FILE: hw/rtl/obst_back.sv
// ---------------------------------------------------------------------------
// Back part
// Executes updates against the slot store and steps the snapshot walk.
// ---------------------------------------------------------------------------
module obst_back #(
    parameter int NUM_TICKERS       = obst_pkg::NUM_TICKERS_DEF,
    parameter int ORDERS_PER_TICKER = obst_pkg::ORDERS_PER_TICKER_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  obst_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    output obst_pkg::t_out_item o_item
);
    import obst_pkg::*;

    localparam int TW    = (NUM_TICKERS > 1) ? $clog2(NUM_TICKERS) : 1;
    localparam int OW    = $clog2(ORDERS_PER_TICKER);
    localparam int SLOTS = NUM_TICKERS * ORDERS_PER_TICKER;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic        m_used  [SLOTS];
    logic        m_side  [SLOTS];
    logic [31:0] m_price [SLOTS];
    logic [31:0] m_qty   [SLOTS];

    t_bk_state   r_state, n_state;
    t_walk_phase r_phase, n_phase;
    logic [TW-1:0] r_wtick, n_wtick;
    logic [OW:0]   r_wslot, n_wslot;
    logic [15:0]   r_mcnt, n_mcnt;
    logic [31:0]   r_last, n_last;
    logic [AW:0]   r_clr, n_clr;

    logic [AW-1:0] w_addr;
    logic [AW-1:0] r_addr;
    logic          r_rd_used, r_rd_side;
    logic [31:0]   r_rd_price, r_rd_qty;
    logic          w_we_used;
    logic          w_used_val;
    logic          w_we_data;
    logic          w_we_side;
    logic          n_valid;
    t_out_item     n_item;
    logic          w_pop;

    always_comb begin
        if (r_state == BK_CLEAR_PASS) begin
            w_addr = r_clr[AW-1:0];
        end else if (r_state == BK_SCAN) begin
            w_addr = AW'(32'(r_wtick) * 32'(ORDERS_PER_TICKER) + 32'(r_wslot[OW-1:0]));
        end else begin
            w_addr = AW'(32'(i_cmd.ticker) * 32'(ORDERS_PER_TICKER)
                   + 32'(i_cmd.order_id));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_used) begin
            m_used[r_state == BK_CLEAR_PASS ? w_addr : r_addr] <= w_used_val;
        end
        if (w_we_data) begin
            m_price[r_addr] <= i_cmd.price;
            m_qty[r_addr]   <= i_cmd.qty;
        end
        if (w_we_side) begin
            m_side[r_addr] <= i_cmd.side;
        end
        r_rd_used  <= m_used[w_addr];
        r_rd_side  <= m_side[w_addr];
        r_rd_price <= m_price[w_addr];
        r_rd_qty   <= m_qty[w_addr];
        r_addr     <= w_addr;
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_wtick = r_wtick;
        n_wslot = r_wslot;
        n_mcnt  = r_mcnt;
        n_last  = r_last;
        n_clr   = r_clr;
        case (r_state)
            BK_CLEAR_PASS: begin
                n_clr = r_clr + 1'b1;
                if (32'(r_clr) == SLOTS - 1) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!i_empty) begin
                    if (!i_cmd.tick) begin
                        n_state = BK_READ;
                    end else begin
                        case (r_phase)
                            PH_IDLE: begin
                                n_mcnt  = 16'd1;
                                n_wtick = '0;
                                n_wslot = '0;
                                n_phase = PH_CLEAR;
                            end
                            PH_CLEAR: begin
                                n_mcnt  = r_mcnt + 16'd1;
                                n_wslot = '0;
                                n_phase = PH_ORDERS;
                            end
                            default: n_state = BK_SCAN;
                        endcase
                    end
                end
            end
            BK_READ: n_state = BK_UPD;
            BK_UPD: begin
                n_last  = i_cmd.seq_num;
                n_state = BK_IDLE;
            end
            BK_SCAN: begin
                if (32'(r_wslot) >= ORDERS_PER_TICKER) begin
                    n_mcnt = r_mcnt + 16'd1;
                    if (32'(r_wtick) + 1 < NUM_TICKERS) begin
                        n_wtick = r_wtick + 1'b1;
                        n_wslot = '0;
                    end else begin
                        n_phase = PH_IDLE;
                        n_wtick = '0;
                        n_wslot = '0;
                    end
                    n_state = BK_IDLE;
                end else begin
                    n_wslot = r_wslot + 1'b1;
                    n_state = BK_SCAN_RD;
                end
            end
            BK_SCAN_RD: begin
                if (r_rd_used) begin
                    n_mcnt  = r_mcnt + 16'd1;
                    n_state = BK_IDLE;
                end else begin
                    n_state = BK_SCAN;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        w_we_used  = 1'b0;
        w_used_val = 1'b0;
        w_we_data  = 1'b0;
        w_we_side  = 1'b0;
        w_pop      = 1'b0;
        n_valid    = 1'b0;
        n_item     = '0;
        case (r_state)
            BK_CLEAR_PASS: begin
                w_we_used = 1'b1;
            end
            BK_IDLE: begin
                if (!i_empty && i_cmd.tick) begin
                    if (r_phase == PH_IDLE) begin
                        w_pop                 = 1'b1;
                        n_valid               = 1'b1;
                        n_item.msg_type       = MSG_START;
                        n_item.id_or_last_seq = r_last;
                    end else if (r_phase == PH_CLEAR) begin
                        w_pop             = 1'b1;
                        n_valid           = 1'b1;
                        n_item.msg_type   = MSG_CLEAR;
                        n_item.msg_seq    = r_mcnt;
                        n_item.out_ticker = 3'(r_wtick);
                    end
                end
            end
            BK_UPD: begin
                w_pop          = 1'b1;
                n_valid        = 1'b1;
                n_item.seq_gap = i_cmd.seq_gap;
                if (i_cmd.update_type != UPD_OTHER) begin
                    if (!i_cmd.in_range) begin
                        n_item.status = ST_MISSING;
                    end else if (i_cmd.update_type == UPD_ADD) begin
                        if (r_rd_used) begin
                            n_item.status = ST_DUP;
                        end else begin
                            w_we_used  = 1'b1;
                            w_used_val = 1'b1;
                            w_we_data  = 1'b1;
                            w_we_side  = 1'b1;
                        end
                    end else if (!r_rd_used) begin
                        n_item.status = ST_MISSING;
                    end else if (r_rd_side != i_cmd.side) begin
                        n_item.status = ST_SIDE;
                    end else if (i_cmd.update_type == UPD_MODIFY) begin
                        w_we_data = 1'b1;
                    end else begin
                        w_we_used = 1'b1;
                    end
                end
            end
            BK_SCAN: begin
                if (32'(r_wslot) >= ORDERS_PER_TICKER) begin
                    w_pop   = 1'b1;
                    n_valid = 1'b1;
                    n_item.msg_seq = r_mcnt;
                    if (32'(r_wtick) + 1 < NUM_TICKERS) begin
                        n_item.msg_type   = MSG_CLEAR;
                        n_item.out_ticker = 3'(r_wtick + 1'b1);
                    end else begin
                        n_item.msg_type         = MSG_END;
                        n_item.id_or_last_seq   = r_last;
                        n_item.last_of_snapshot = 1'b1;
                    end
                end
            end
            BK_SCAN_RD: begin
                if (r_rd_used) begin
                    w_pop                 = 1'b1;
                    n_valid               = 1'b1;
                    n_item.msg_type       = MSG_ORDER;
                    n_item.msg_seq        = r_mcnt;
                    n_item.out_ticker     = 3'(r_wtick);
                    n_item.id_or_last_seq = 32'(r_wslot - 1'b1);
                    n_item.out_side       = r_rd_side;
                    n_item.out_price      = r_rd_price;
                    n_item.out_qty        = r_rd_qty;
                end
            end
            default: ;
        endcase
    end

    assign o_pop = w_pop;

    always_ff @(posedge i_clk) begin
        o_item <= n_item;
        if (!i_rst_n) begin
            r_state <= BK_CLEAR_PASS;
            r_phase <= PH_IDLE;
            r_wtick <= '0;
            r_wslot <= '0;
            r_mcnt  <= '0;
            r_last  <= '0;
            r_clr   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_wtick <= n_wtick;
            r_wslot <= n_wslot;
            r_mcnt  <= n_mcnt;
            r_last  <= n_last;
            r_clr   <= n_clr;
            o_valid <= n_valid;
        end
    end

endmodule

FILE: hw/rtl/order_book_snapshot_table_top.sv
// ---------------------------------------------------------------------------
// Order book snapshot table
// Per-ticker live order table with an incremental snapshot walk.
// ---------------------------------------------------------------------------
// Update: passes the queue, a table read, the write and the output register.
// Tick: START/CLEAR answer from idle; an order tick reads and tests slots in turn.
// Back part finishes one update before taking the next; two items may queue ahead.
// Reset: clearing pass over all NUM_TICKERS*ORDERS_PER_TICKER slots; two transfers
// queue during it, then busy holds until the pass ends.
// Results are strobed for one cycle; the receiver cannot stall.
module order_book_snapshot_table_top #(
    parameter int NUM_TICKERS       = obst_pkg::NUM_TICKERS_DEF,
    parameter int ORDERS_PER_TICKER = obst_pkg::ORDERS_PER_TICKER_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  obst_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output obst_pkg::t_out_item o_item
);
    import obst_pkg::*;
    `include "order_book_snapshot_table_top_macros.svh"

    logic q_full, q_empty, q_push, q_pop;
    t_cmd f_cmd, q_cmd;

    obst_front #(.NUM_TICKERS(NUM_TICKERS), .ORDERS_PER_TICKER(ORDERS_PER_TICKER)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_item(i_item),
        .i_q_full(q_full), .o_busy(busy), .o_push(q_push), .o_cmd(f_cmd)
    );

    obst_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(q_push), .i_cmd(f_cmd),
        .i_pop(q_pop), .o_full(q_full), .o_empty(q_empty), .o_cmd(q_cmd)
    );

    obst_back #(.NUM_TICKERS(NUM_TICKERS), .ORDERS_PER_TICKER(ORDERS_PER_TICKER)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(q_empty), .i_cmd(q_cmd),
        .o_pop(q_pop), .o_valid(o_strobe), .o_item(o_item)
    );

    `OBS_ASSERT_IMPL(a_pop_not_empty, i_clk, i_rst_n, q_pop, !q_empty)
    `OBS_ASSERT_NEXT(a_pop_strobes, i_clk, i_rst_n, q_pop, o_strobe)
    `OBS_ASSERT_IMPL(a_end_last, i_clk, i_rst_n, o_strobe && o_item.last_of_snapshot, o_item.msg_type == MSG_END)

endmodule

FILE: test/tb_top.sv
// ---------------------------------------------------------------------------
// Order book snapshot table testbench
// Drives update transfers and snapshot ticks, mirrors the order table in a
// scoreboard class and checks each strobed message field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import obst_pkg::*;

    localparam int NT = NUM_TICKERS_DEF;
    localparam int NO = ORDERS_PER_TICKER_DEF;
    localparam int LIMIT = 3000000;

    class book_board;
        bit          used  [NT*NO];
        logic [31:0] price [NT*NO];
        logic [31:0] qty   [NT*NO];
        logic        side  [NT*NO];
        logic [31:0] last_seq;
        t_walk_phase phase;
        int          wtick;
        int          wslot;
        logic [15:0] msg_cnt;
        t_out_item   pending [$];
        int          errors;
        int          n_ord;
        int          n_end;

        function new();
            last_seq = 0;
            phase = PH_IDLE;
            wtick = 0;
            wslot = 0;
            msg_cnt = 0;
            errors = 0;
            n_ord = 0;
            n_end = 0;
        endfunction

        function void push_msg(logic [2:0] mt, int tk, logic [31:0] id,
                               logic sd, logic [31:0] pr, logic [31:0] q,
                               logic [1:0] st, logic gp, logic lst);
            t_out_item m;
            m = '0;
            m.msg_type = mt;
            m.msg_seq = (mt == MSG_STATUS) ? 16'd0 : msg_cnt;
            m.out_ticker = tk[2:0];
            m.id_or_last_seq = id;
            m.out_side = sd;
            m.out_price = pr;
            m.out_qty = q;
            m.status = st;
            m.seq_gap = gp;
            m.last_of_snapshot = lst;
            if (mt != MSG_STATUS) msg_cnt++;
            pending.push_back(m);
        endfunction

        function void note_transfer(t_in_item it);
            logic [1:0] st;
            logic gp;
            int s;
            st = ST_OK;
            if (!it.kind) begin
                gp = (it.seq_num != last_seq + 32'd1);
                s = it.ticker * NO + it.order_id;
                if (it.update_type != UPD_OTHER) begin
                    if (it.update_type == UPD_ADD) begin
                        if (used[s]) st = ST_DUP;
                        else begin
                            used[s] = 1;
                            side[s] = it.side;
                            price[s] = it.price;
                            qty[s] = it.qty;
                        end
                    end else if (!used[s]) st = ST_MISSING;
                    else if (side[s] != it.side) st = ST_SIDE;
                    else if (it.update_type == UPD_MODIFY) begin
                        price[s] = it.price;
                        qty[s] = it.qty;
                    end else used[s] = 0;
                end
                last_seq = it.seq_num;
                push_msg(MSG_STATUS, 0, 0, 0, 0, 0, st, gp, 0);
                return;
            end
            if (phase == PH_IDLE) begin
                msg_cnt = 0;
                wtick = 0;
                wslot = 0;
                phase = PH_CLEAR;
                push_msg(MSG_START, 0, last_seq, 0, 0, 0, ST_OK, 0, 0);
                return;
            end
            if (phase == PH_CLEAR) begin
                wslot = 0;
                phase = PH_ORDERS;
                push_msg(MSG_CLEAR, wtick, 0, 0, 0, 0, ST_OK, 0, 0);
                return;
            end
            while (wslot < NO) begin
                s = wtick * NO + wslot;
                wslot++;
                if (used[s]) begin
                    n_ord++;
                    push_msg(MSG_ORDER, wtick, s % NO, side[s], price[s], qty[s],
                             ST_OK, 0, 0);
                    return;
                end
            end
            if (wtick + 1 < NT) begin
                wtick++;
                wslot = 0;
                push_msg(MSG_CLEAR, wtick, 0, 0, 0, 0, ST_OK, 0, 0);
                return;
            end
            phase = PH_IDLE;
            wtick = 0;
            wslot = 0;
            n_end++;
            push_msg(MSG_END, 0, last_seq, 0, 0, 0, ST_OK, 0, 1);
        endfunction

        function void check_msg(t_out_item got);
            t_out_item exp;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected message %h", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp: type %0d seq %0d tk %0d id %h sd %b",
                             exp.msg_type, exp.msg_seq, exp.out_ticker,
                             exp.id_or_last_seq, exp.out_side);
                    $display("  pr %h q %h st %0d gap %b last %b",
                             exp.out_price, exp.out_qty, exp.status,
                             exp.seq_gap, exp.last_of_snapshot);
                    $display("         got: type %0d seq %0d tk %0d id %h sd %b",
                             got.msg_type, got.msg_seq, got.out_ticker,
                             got.id_or_last_seq, got.out_side);
                    $display("  pr %h q %h st %0d gap %b last %b",
                             got.out_price, got.out_qty, got.status,
                             got.seq_gap, got.last_of_snapshot);
                end
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_strobe;
    t_out_item o_item;

    book_board board;
    int        cycles;
    logic [31:0] seq_ctr;
    int        n_upd;

    order_book_snapshot_table_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_strobe(o_strobe), .o_item(o_item)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) board.check_msg(o_item);
    end

    task automatic send(t_in_item it);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        board.note_transfer(it);
        if (!it.kind) n_upd++;
    endtask

    function automatic t_in_item mk_upd(logic [1:0] ut, int tk, int id, logic sd,
                                        logic [31:0] pr, logic [31:0] q);
        t_in_item it;
        it = '0;
        it.kind = 1'b0;
        it.update_type = ut;
        seq_ctr = ($urandom_range(0, 15) == 0) ? $urandom : seq_ctr + 32'd1;
        it.seq_num = seq_ctr;
        it.ticker = tk[2:0];
        it.order_id = id[9:0];
        it.side = sd;
        it.price = pr;
        it.qty = q;
        return it;
    endfunction

    function automatic t_in_item mk_tick();
        t_in_item it;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        it.kind = 1'b1;
        return it;
    endfunction

    initial begin
        t_in_item it;
        int tk;
        int id;
        board = new();
        cycles = 0;
        seq_ctr = 0;
        n_upd = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, every type, each fault
        send(mk_upd(UPD_ADD, 0, 0, 0, 32'h8000_0000, 32'd0));
        send(mk_upd(UPD_ADD, 7, 1023, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send(mk_upd(UPD_ADD, 7, 1023, 1, 32'd5, 32'd5));
        send(mk_upd(UPD_MODIFY, 7, 1023, 0, 32'd1, 32'd1));
        send(mk_upd(UPD_MODIFY, 7, 1023, 1, 32'hFFFF_FFFF, 32'd77));
        send(mk_upd(UPD_MODIFY, 3, 100, 0, 32'd1, 32'd1));
        send(mk_upd(UPD_CANCEL, 3, 100, 1, 32'd1, 32'd1));
        send(mk_upd(UPD_CANCEL, 0, 0, 1, 32'd0, 32'd0));
        send(mk_upd(UPD_OTHER, 2, 2, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        it = mk_upd(UPD_ADD, 0, 512, 0, 32'd9, 32'd9);
        it.seq_num = 32'hFFFF_FFFF;
        seq_ctr = it.seq_num;
        send(it);
        send(mk_upd(UPD_ADD, 4, 7, 1, 32'd3, 32'd4));
        repeat (14) send(mk_tick());
        send(mk_upd(UPD_CANCEL, 0, 0, 0, 32'd0, 32'd0));
        send(mk_upd(UPD_ADD, 0, 1, 0, 32'd0, 32'd0));

        // random: in-range updates of random type, mostly on a small set of ids, rare ticks
        for (int n = 0; n < 850; n++) begin
            if ($urandom_range(0, 9) == 0) send(mk_tick());
            else begin
                tk = $urandom_range(0, 7);
                id = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, 5) * 200;
                send(mk_upd(2'($urandom_range(0, 3)), tk, id, 1'($urandom_range(0, 1)),
                            $urandom, $urandom));
            end
        end
        // close any walk still open
        while (board.phase != PH_IDLE) send(mk_tick());
        start <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("ran %0d updates, %0d order messages over %0d complete snapshots",
                 n_upd, board.n_ord, board.n_end);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", board.errors);
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
